// File: design/bfra_pkg.sv
package bfra_pkg;

   localparam int FREE_SLOTS_DEF = 16;
   localparam int SIZE_W = 25;
   localparam int OFFS_W = 24;
   localparam int SUM_W = 26;
   localparam logic [SIZE_W-1:0] CAP_RESET = 25'd65536;
   localparam logic [SIZE_W-1:0] CAP_MAX = 25'd16777216;
   localparam logic [SIZE_W-1:0] TOP_RESET = 25'd1;
   localparam logic [SIZE_W-1:0] LEN_MAX = 25'h1FFFFFF;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_LIST_FULL = 2'd2
   } status_type;

   typedef enum logic {
      OP_BEST_FIT = 1'b0,
      OP_MERGE = 1'b1
   } scan_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ALLOC_SCAN = 2'd1,
      ST_FREE_SCAN = 2'd2
   } state_type;

   typedef struct packed {
      logic valid;
      logic found;
      logic kind;
      logic [OFFS_W-1:0] start;
      logic [SIZE_W-1:0] len;
   } token_type;

endpackage

// File: design/bfra_if.sv
interface bfra_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [bfra_pkg::SIZE_W-1:0] req_size;
   logic [bfra_pkg::OFFS_W-1:0] free_offset;
   modport source (output valid, mode, req_size, free_offset, input ready);
   modport sink (input valid, mode, req_size, free_offset, output ready);
endinterface

interface bfra_rsp_if;
   logic valid;
   logic ready;
   logic [bfra_pkg::OFFS_W-1:0] alloc_offset;
   logic [1:0] status;
   modport source (output valid, alloc_offset, status, input ready);
   modport sink (input valid, alloc_offset, status, output ready);
endinterface

// File: design/bfra_cell.sv
module bfra_cell #(
   parameter int SLOTS = bfra_pkg::FREE_SLOTS_DEF + 1,
   parameter int IDX = 0
) (
   input  logic clock,
   input  logic reset,
   input  bfra_pkg::scan_op_type op,
   input  logic [$clog2(SLOTS+1)-1:0] limit,
   input  logic [bfra_pkg::SIZE_W-1:0] req_size,
   input  logic [$clog2(SLOTS)-1:0] b_idx,
   input  logic [bfra_pkg::OFFS_W-1:0] b_start,
   input  logic [bfra_pkg::SIZE_W-1:0] b_len,
   input  logic wa_en,
   input  logic [bfra_pkg::OFFS_W-1:0] wa_start,
   input  logic [bfra_pkg::SIZE_W-1:0] wa_len,
   input  logic wb_en,
   input  logic [bfra_pkg::OFFS_W-1:0] wb_start,
   input  logic [bfra_pkg::SIZE_W-1:0] wb_len,
   input  bfra_pkg::token_type tok_in,
   input  logic [$clog2(SLOTS)-1:0] idx_in,
   output bfra_pkg::token_type tok_out,
   output logic [$clog2(SLOTS)-1:0] idx_out,
   output logic [bfra_pkg::OFFS_W-1:0] slot_start,
   output logic [bfra_pkg::SIZE_W-1:0] slot_len
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS+1);

   logic [bfra_pkg::OFFS_W-1:0] start_ff;
   logic [bfra_pkg::SIZE_W-1:0] len_ff;
   bfra_pkg::token_type tok_ff, tok_in_next;
   logic [IW-1:0] idx_ff, idx_in_next;
   logic active, hit, ends_at_b, b_ends_here;
   logic [bfra_pkg::SUM_W-1:0] end_own, end_b;

   always_comb begin
      active = CW'(IDX) < limit;
      end_own = {2'b0, start_ff} + {1'b0, len_ff};
      end_b = {2'b0, b_start} + {1'b0, b_len};
      ends_at_b = end_own == {2'b0, b_start};
      b_ends_here = end_b == {2'b0, start_ff};
      if (op == bfra_pkg::OP_BEST_FIT) begin
         hit = active && (len_ff >= req_size) && (!tok_in.found || len_ff < tok_in.len);
      end else begin
         hit = active && (IW'(IDX) != b_idx) && !tok_in.found && (ends_at_b || b_ends_here);
      end
      tok_in_next = tok_in;
      idx_in_next = idx_in;
      if (tok_in.valid && hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.kind = ends_at_b;
         tok_in_next.start = start_ff;
         tok_in_next.len = len_ff;
         idx_in_next = IW'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
      idx_ff <= idx_in_next;
      if (wb_en) begin
         start_ff <= wb_start;
         len_ff <= wb_len;
      end else if (wa_en) begin
         start_ff <= wa_start;
         len_ff <= wa_len;
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;
   assign slot_start = start_ff;
   assign slot_len = len_ff;

endmodule

// File: design/best_fit_range_allocator_core.sv
// A zero-size request or a free that ends at the top pointer answers in the cycle after
// acceptance. Any other request makes one pass of a scan token through the cell chain.
// Each merge of a free adds another pass through the chain, so a free takes one pass
// more than the number of merges that it makes.
// One transaction is worked at a time, and the next one is accepted in the cycle after
// the result is taken, so the scan passes set the throughput.
// Synchronous active-high reset sets capacity to 65536, the top pointer to 1 and
// empties the free list; slot contents are not cleared.
module best_fit_range_allocator_core #(
   parameter int FREE_SLOTS = bfra_pkg::FREE_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   bfra_req_if.sink req_chan,
   bfra_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [bfra_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int SLOTS = FREE_SLOTS + 1;
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS+1);
   localparam int SW = bfra_pkg::SIZE_W;
   localparam int OW = bfra_pkg::OFFS_W;

   bfra_pkg::state_type state_ff, state_in;
   bfra_pkg::scan_op_type op_ff, op_in;
   logic [SW-1:0] cap_ff, top_ff, top_in, size_ff, size_in;
   logic [CW-1:0] count_ff, count_in, limit_ff, limit_in;
   logic [IW-1:0] b_idx_ff, b_idx_in;
   logic [OW-1:0] b_start_ff, b_start_in;
   logic [SW-1:0] b_len_ff, b_len_in;
   logic launch_ff, launch_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_offset_ff, rsp_offset_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   bfra_pkg::token_type tok_chain [SLOTS+1];
   logic [IW-1:0] idx_chain [SLOTS+1];
   logic [OW-1:0] slot_st [SLOTS];
   logic [SW-1:0] slot_ln [SLOTS];

   logic wa_v, wb_v;
   logic [IW-1:0] wa_idx, wb_idx, last_idx, keep_idx, gone_idx;
   logic [OW-1:0] wa_start, wb_start, keep_start;
   logic [SW-1:0] wa_len, wb_len, new_len;
   logic [bfra_pkg::SUM_W-1:0] sum;
   logic req_ready;
   bfra_pkg::token_type tail;

   assign req_ready = (state_ff == bfra_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.alloc_offset = rsp_offset_ff;
   assign rsp_chan.status = rsp_status_ff;

   always_comb begin
      tok_chain[0] = '0;
      tok_chain[0].valid = launch_ff;
      idx_chain[0] = '0;
   end

   generate
      for (genvar k = 0; k < SLOTS; k++) begin : g_cell
         bfra_cell #(.SLOTS(SLOTS), .IDX(k)) u_cell (
            .clock(clock),
            .reset(reset),
            .op(op_ff),
            .limit(limit_ff),
            .req_size(size_ff),
            .b_idx(b_idx_ff),
            .b_start(b_start_ff),
            .b_len(b_len_ff),
            .wa_en(wa_v && (wa_idx == IW'(k))),
            .wa_start(wa_start),
            .wa_len(wa_len),
            .wb_en(wb_v && (wb_idx == IW'(k))),
            .wb_start(wb_start),
            .wb_len(wb_len),
            .tok_in(tok_chain[k]),
            .idx_in(idx_chain[k]),
            .tok_out(tok_chain[k+1]),
            .idx_out(idx_chain[k+1]),
            .slot_start(slot_st[k]),
            .slot_len(slot_ln[k])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      top_in = top_ff;
      size_in = size_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      b_idx_in = b_idx_ff;
      b_start_in = b_start_ff;
      b_len_in = b_len_ff;
      launch_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      wa_v = 1'b0;
      wa_idx = '0;
      wa_start = '0;
      wa_len = '0;
      wb_v = 1'b0;
      wb_idx = '0;
      wb_start = '0;
      wb_len = '0;
      tail = tok_chain[SLOTS];
      last_idx = IW'(limit_ff - CW'(1));
      keep_idx = tail.kind ? idx_chain[SLOTS] : b_idx_ff;
      gone_idx = tail.kind ? b_idx_ff : idx_chain[SLOTS];
      keep_start = tail.kind ? tail.start : b_start_ff;
      sum = {1'b0, tail.len} + {1'b0, b_len_ff};
      new_len = sum[SW] ? bfra_pkg::LEN_MAX : sum[SW-1:0];

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bfra_pkg::ST_IDLE: begin
            if (req_chan.valid && req_ready) begin
               size_in = req_chan.req_size;
               rsp_offset_in = '0;
               rsp_status_in = bfra_pkg::STAT_OK;
               if (req_chan.req_size == '0) begin
                  rsp_valid_in = 1'b1;
               end else if (!req_chan.mode) begin
                  op_in = bfra_pkg::OP_BEST_FIT;
                  limit_in = count_ff;
                  launch_in = 1'b1;
                  state_in = bfra_pkg::ST_ALLOC_SCAN;
               end else if ({2'b0, req_chan.free_offset} + {1'b0, req_chan.req_size}
                            == {1'b0, top_ff}) begin
                  top_in = top_ff - req_chan.req_size;
                  rsp_valid_in = 1'b1;
               end else begin
                  wa_v = 1'b1;
                  wa_idx = IW'(count_ff);
                  wa_start = req_chan.free_offset;
                  wa_len = req_chan.req_size;
                  b_idx_in = IW'(count_ff);
                  b_start_in = req_chan.free_offset;
                  b_len_in = req_chan.req_size;
                  limit_in = count_ff + CW'(1);
                  op_in = bfra_pkg::OP_MERGE;
                  launch_in = 1'b1;
                  state_in = bfra_pkg::ST_FREE_SCAN;
               end
            end
         end
         bfra_pkg::ST_ALLOC_SCAN: begin
            if (tail.valid) begin
               state_in = bfra_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (tail.found) begin
                  rsp_offset_in = tail.start;
                  wa_v = 1'b1;
                  wa_idx = idx_chain[SLOTS];
                  if (tail.len == size_ff) begin
                     wa_start = slot_st[last_idx];
                     wa_len = slot_ln[last_idx];
                     count_in = count_ff - CW'(1);
                  end else begin
                     wa_start = tail.start + size_ff[OW-1:0];
                     wa_len = tail.len - size_ff;
                  end
               end else if ({1'b0, top_ff} + {1'b0, size_ff} > {1'b0, cap_ff}) begin
                  rsp_status_in = bfra_pkg::STAT_NO_SPACE;
               end else begin
                  rsp_offset_in = top_ff[OW-1:0];
                  top_in = top_ff + size_ff;
               end
            end
         end
         bfra_pkg::ST_FREE_SCAN: begin
            if (tail.valid) begin
               if (tail.found) begin
                  wa_v = 1'b1;
                  wa_idx = keep_idx;
                  wa_start = keep_start;
                  wa_len = new_len;
                  wb_v = 1'b1;
                  wb_idx = gone_idx;
                  if (keep_idx == last_idx) begin
                     wb_start = keep_start;
                     wb_len = new_len;
                     b_idx_in = gone_idx;
                  end else begin
                     wb_start = slot_st[last_idx];
                     wb_len = slot_ln[last_idx];
                     b_idx_in = keep_idx;
                  end
                  b_start_in = keep_start;
                  b_len_in = new_len;
                  limit_in = limit_ff - CW'(1);
                  launch_in = 1'b1;
               end else begin
                  state_in = bfra_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
                  if (limit_ff > CW'(FREE_SLOTS)) begin
                     rsp_status_in = bfra_pkg::STAT_LIST_FULL;
                  end else begin
                     count_in = limit_ff;
                  end
               end
            end
         end
         default: begin
            state_in = bfra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfra_pkg::ST_IDLE;
         cap_ff <= bfra_pkg::CAP_RESET;
         top_ff <= bfra_pkg::TOP_RESET;
         count_ff <= '0;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff <= top_in;
         count_ff <= count_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= (csr_wdata > bfra_pkg::CAP_MAX) ? bfra_pkg::CAP_MAX : csr_wdata;
         end
      end
      op_ff <= op_in;
      size_ff <= size_in;
      limit_ff <= limit_in;
      b_idx_ff <= b_idx_in;
      b_start_ff <= b_start_in;
      b_len_ff <= b_len_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FREE_SLOTS))
      else $error("free list count exceeds the slot count");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      cap_ff <= bfra_pkg::CAP_MAX)
      else $error("capacity above its maximum");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after an accepted transaction");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[SLOTS].valid |-> (state_ff == bfra_pkg::ST_ALLOC_SCAN ||
                                  state_ff == bfra_pkg::ST_FREE_SCAN))
      else $error("scan token arrived outside a scan");

endmodule
